// ===== hdl/tbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types and constants for the tape block stream checker: word
// layouts of both channels, parser phases and result status codes.
// ----------------------------------------------------------------------------
package tbsc_pkg;

  localparam int unsigned HEADER_LEN = 19;
  localparam int unsigned HDR_BYTES  = 17;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES + 1);
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_PARITY = '0;

  typedef enum logic [2:0] {
    PH_LEN_LO  = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_FLAG    = 3'd2,
    PH_BODY    = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_SHORT_LEN = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_offset;
    logic [15:0] payload_length;
    logic [7:0]  flag_value;
    logic        is_header;
    logic [7:0]  header_type;
    logic [63:0] name_head;
    logic [15:0] name_tail;
    logic [15:0] data_length_word;
    logic [15:0] param_one;
    logic [15:0] param_two;
    logic        parity_ok;
    status_t     status;
  } out_word_t;

endpackage

// ===== hdl/tape_block_stream_checker_top.sv =====
// ----------------------------------------------------------------------------
// tape_block_stream_checker_top
// Splits a tape image into length-prefixed blocks and checks each block.
//
// Input channel (in_valid / in_stall / in_word): one tape byte per word,
// stream_last set on the final byte of an image. Output channel
// (out_valid / out_stall / out_word): one result word per finished block,
// per block with a length below two (reported on its flag byte) and per
// block cut short by the end of the stream.
// Latency: a result shows on out_word the cycle after the byte that ends
// the block is accepted. Throughput: one byte per cycle unless stalled;
// all parsing is a single stage of logic into a one-word output register.
// When the receiver stalls with a result waiting, in_stall rises and the
// input holds until the result is taken; a waiting result does not block
// bytes while the output register is empty or draining.
// Reset clears the parser to expect a length low byte at stream offset
// zero and empties the output register; check_parity resets to 0.
// Config: register check_parity at byte address 0 (bit 0).
// ----------------------------------------------------------------------------
module tape_block_stream_checker_top
  import tbsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  phase_t               phase_r, phase_nxt;
  logic [15:0]          block_len_r, block_len_nxt;
  logic [15:0]          bytes_left_r, bytes_left_nxt;
  logic [7:0]           flag_r, flag_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [7:0]           hdr_r [HDR_BYTES];
  logic [7:0]           hdr_nxt [HDR_BYTES];
  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic [31:0]          stream_pos_r, stream_pos_nxt;
  logic [31:0]          block_start_r, block_start_nxt;
  logic                 check_parity_r;
  logic                 out_valid_r;
  out_word_t            out_word_r, res_word;

  logic    accept;
  logic    last;
  logic    emit;
  logic    have_len;
  logic    have_flag;
  logic    hdr_hit;
  status_t res_status;

  assign accept = in_valid && !in_stall;
  assign last   = in_word.stream_last;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, check_parity_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_parity_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_CHECK_PARITY) begin
      check_parity_r <= cfg_pwdata[0];
    end
  end

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_LEN_LO:  phase_nxt = PH_LEN_HI;
        PH_LEN_HI:  phase_nxt = PH_FLAG;
        PH_FLAG:    phase_nxt = (block_len_r < 16'd2) ? PH_DISCARD : PH_BODY;
        PH_BODY:    phase_nxt = (bytes_left_r == 16'd1) ? PH_LEN_LO : PH_BODY;
        PH_DISCARD: phase_nxt = PH_DISCARD;
        default:    phase_nxt = PH_LEN_LO;
      endcase
      if (last) begin
        phase_nxt = PH_LEN_LO;
      end
    end
  end

  // datapath and result selection
  always_comb begin
    block_len_nxt   = block_len_r;
    bytes_left_nxt  = bytes_left_r;
    flag_nxt        = flag_r;
    xor_nxt         = xor_r;
    hdr_idx_nxt     = hdr_idx_r;
    block_start_nxt = block_start_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    emit       = 1'b0;
    have_len   = 1'b1;
    have_flag  = 1'b1;
    res_status = ST_TRUNCATED;

    case (phase_r)
      PH_LEN_LO: begin
        block_start_nxt = stream_pos_r;
        block_len_nxt   = {8'd0, in_word.data_byte};
        have_len        = 1'b0;
        have_flag       = 1'b0;
        emit            = last;
      end
      PH_LEN_HI: begin
        block_len_nxt = {in_word.data_byte, block_len_r[7:0]};
        have_flag     = 1'b0;
        emit          = last;
      end
      PH_FLAG: begin
        flag_nxt    = in_word.data_byte;
        xor_nxt     = in_word.data_byte;
        hdr_idx_nxt = '0;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr_nxt[i] = 8'd0;
        end
        if (block_len_r < 16'd2) begin
          emit       = 1'b1;
          res_status = ST_SHORT_LEN;
        end else begin
          bytes_left_nxt = block_len_r - 16'd1;
          emit           = last;
        end
      end
      PH_BODY: begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (hdr_idx_r == HDR_IDX_W'(i)) begin
            hdr_nxt[i] = in_word.data_byte;
          end
        end
        if (hdr_idx_r < HDR_IDX_W'(HDR_BYTES)) begin
          hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
        end
        xor_nxt        = xor_r ^ in_word.data_byte;
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          emit       = 1'b1;
          res_status = ST_COMPLETE;
        end else begin
          emit = last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    stream_pos_nxt = last ? 32'd0 : stream_pos_r + 32'd1;

    hdr_hit = have_flag && block_len_nxt == 16'(HEADER_LEN) && flag_nxt == 8'd0;

    res_word                = '0;
    res_word.block_offset   = block_start_nxt;
    res_word.payload_length = (have_len && block_len_nxt >= 16'd2) ?
                              block_len_nxt - 16'd2 : 16'd0;
    res_word.flag_value     = have_flag ? flag_nxt : 8'd0;
    res_word.is_header      = hdr_hit;
    if (hdr_hit) begin
      res_word.header_type = hdr_nxt[0];
      for (int i = 0; i < 8; i++) begin
        res_word.name_head[8*i +: 8] = hdr_nxt[1+i];
      end
      res_word.name_tail        = {hdr_nxt[10], hdr_nxt[9]};
      res_word.data_length_word = {hdr_nxt[12], hdr_nxt[11]};
      res_word.param_one        = {hdr_nxt[14], hdr_nxt[13]};
      res_word.param_two        = {hdr_nxt[16], hdr_nxt[15]};
    end
    res_word.parity_ok = (res_status == ST_COMPLETE) &&
                         (!check_parity_r || xor_nxt == 8'd0);
    res_word.status    = res_status;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN_LO;
      block_len_r   <= '0;
      bytes_left_r  <= '0;
      flag_r        <= '0;
      xor_r         <= '0;
      hdr_idx_r     <= '0;
      stream_pos_r  <= '0;
      block_start_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      block_len_r   <= block_len_nxt;
      bytes_left_r  <= bytes_left_nxt;
      flag_r        <= flag_nxt;
      xor_r         <= xor_nxt;
      hdr_idx_r     <= hdr_idx_nxt;
      stream_pos_r  <= stream_pos_nxt;
      block_start_r <= block_start_nxt;
    end
  end

  // header bytes, read only after the flag byte clears them
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word_r <= res_word;
    end
  end

  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
